### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### rtl/core/ptdc_pkg.sv
// Types, codes and constants of the pan/tilt deadband P controller.
// No dependencies.
package ptdc_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int DIM_BITS       = 12;
  localparam int ADDR_BITS      = 5;
  localparam int Q_BITS         = 15;
  localparam int BITS_PER_STAGE = 3;
  localparam int DIV_STAGES     = Q_BITS / BITS_PER_STAGE;
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam int PROD_SHIFT     = 11;

  typedef enum logic [1:0] {
    ST_DRIVEN   = 2'd0,
    ST_LOW_CONF = 2'd1,
    ST_BAD_GEOM = 2'd2
  } ptdc_status_t;

  typedef enum logic [2:0] {
    REG_CONF_FLOOR = 3'd0,
    REG_WIDTH      = 3'd1,
    REG_HEIGHT     = 3'd2,
    REG_DEAD_ZONE  = 3'd3,
    REG_PAN_GAIN   = 3'd4,
    REG_TILT_GAIN  = 3'd5,
    REG_PAN_LIMIT  = 3'd6,
    REG_TILT_LIMIT = 3'd7
  } ptdc_reg_t;

  typedef struct packed {
    logic [31:0] frame_tag;
    logic [15:0] target_confidence;
    logic [15:0] centroid_x;
    logic [15:0] centroid_y;
  } ptdc_in_t;

  typedef struct packed {
    logic [31:0]        frame_tag_out;
    logic signed [15:0] pan_setpoint;
    logic signed [15:0] tilt_setpoint;
    logic [1:0]         drive_status;
  } ptdc_out_t;

endpackage

### rtl/core/ptdc_div.sv
// Two-lane pipelined restoring divider, fraction quotient of Q_BITS bits.
// Needs rem < den on entry; depends on ptdc_pkg.
module ptdc_div #(
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [1:0][DW-1:0]            rem_i,
  input  logic [1:0][DW-1:0]            den_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic [1:0][ptdc_pkg::Q_BITS-1:0] q_o,
  output logic [SW-1:0]                 side_o
);
  import ptdc_pkg::*;

  logic                    vld_r  [DIV_STAGES];
  logic [1:0][DW-1:0]      rem_r  [DIV_STAGES];
  logic [1:0][DW-1:0]      den_r  [DIV_STAGES];
  logic [1:0][Q_BITS-1:0]  q_r    [DIV_STAGES];
  logic [SW-1:0]           side_r [DIV_STAGES];

  logic [1:0][DW-1:0]      rem_nxt [DIV_STAGES];
  logic [1:0][Q_BITS-1:0]  q_nxt   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [1:0][DW-1:0]     rem_in;
    logic [1:0][DW-1:0]     den_in;
    logic [1:0][Q_BITS-1:0] q_in;
    logic                   vld_in;
    logic [SW-1:0]          side_in;

    if (s == 0) begin : g_first
      assign rem_in  = rem_i;
      assign den_in  = den_i;
      assign q_in    = '0;
      assign vld_in  = vld_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign q_in    = q_r[s-1];
      assign vld_in  = vld_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      logic [DW:0]       t;
      logic [DW-1:0]     r;
      logic [Q_BITS-1:0] q;
      for (int l = 0; l < 2; l++) begin
        r = rem_in[l];
        q = q_in[l];
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
          t = {r, 1'b0};
          if (t >= {1'b0, den_in[l]}) begin
            t = t - {1'b0, den_in[l]};
            q = {q[Q_BITS-2:0], 1'b1};
          end else begin
            q = {q[Q_BITS-2:0], 1'b0};
          end
          r = t[DW-1:0];
        end
        rem_nxt[s][l] = r;
        q_nxt[s][l]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt[s];
      q_r[s]    <= q_nxt[s];
      den_r[s]  <= den_in;
      side_r[s] <= side_in;
    end
  end

  assign vld_o  = vld_r[DIV_STAGES-1];
  assign q_o    = q_r[DIV_STAGES-1];
  assign side_o = side_r[DIV_STAGES-1];

endmodule

### rtl/core/pan_tilt_deadband_p_control.sv
// Pan/tilt proportional controller with deadband and clamp, top level.
// Depends on ptdc_pkg, ptdc_div and assert_macros.svh.
//
// Usage:
//   Input channel: drive in_item and pulse start; the item is taken at
//   every edge with start high and busy low. busy is always low, so one
//   item may be sent every clock cycle.
//   Result channel: out_valid is high for one cycle with out_item; the
//   receiver cannot stall, results must be taken when shown.
//   Throughput: one item per cycle. Depth is set by two 5-stage dividers
//   (error normalize and deadband rescale, 3 quotient bits per stage), one
//   input stage, one gain multiply stage and one clamp stage.
//   Configuration: APB-style writes at byte address 4*index; pready is
//   always high. Write only while no item is in flight.
//   Reset: synchronous, active low; clears all in-flight items and loads
//   the register defaults.
`include "assert_macros.svh"
module pan_tilt_deadband_p_control #(
  parameter int PIXEL_BITS = ptdc_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ptdc_pkg::ptdc_in_t            in_item,
  output logic                          out_valid,
  output ptdc_pkg::ptdc_out_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptdc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ptdc_pkg::*;

  localparam int CF  = 16 - PIXEL_BITS;
  localparam int DW1 = DIM_BITS + CF;
  localparam int NW  = ((DW1 > 17) ? DW1 : 17) + 1;
  localparam int SW  = 32 + 2 + 2 + 2;

  // configuration
  logic [15:0]        conf_floor_r;
  logic [11:0]        width_r;
  logic [11:0]        height_r;
  logic [14:0]        dead_zone_r;
  logic signed [15:0] pan_gain_r;
  logic signed [15:0] tilt_gain_r;
  logic [14:0]        pan_limit_r;
  logic [14:0]        tilt_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_floor_r <= 16'd32768;
      width_r      <= 12'd640;
      height_r     <= 12'd480;
      dead_zone_r  <= 15'd0;
      pan_gain_r   <= 16'sd256;
      tilt_gain_r  <= 16'sd256;
      pan_limit_r  <= 15'd4096;
      tilt_limit_r <= 15'd4096;
    end else if (psel && penable && pwrite && pready) begin
      case (ptdc_reg_t'(paddr[4:2]))
        REG_CONF_FLOOR: conf_floor_r <= pwdata[15:0];
        REG_WIDTH:      width_r      <= pwdata[11:0];
        REG_HEIGHT:     height_r     <= pwdata[11:0];
        REG_DEAD_ZONE:  dead_zone_r  <= pwdata[14:0];
        REG_PAN_GAIN:   pan_gain_r   <= pwdata[15:0];
        REG_TILT_GAIN:  tilt_gain_r  <= pwdata[15:0];
        REG_PAN_LIMIT:  pan_limit_r  <= pwdata[14:0];
        REG_TILT_LIMIT: tilt_limit_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ptdc_reg_t'(paddr[4:2]))
      REG_CONF_FLOOR: prdata = {16'd0, conf_floor_r};
      REG_WIDTH:      prdata = {20'd0, width_r};
      REG_HEIGHT:     prdata = {20'd0, height_r};
      REG_DEAD_ZONE:  prdata = {17'd0, dead_zone_r};
      REG_PAN_GAIN:   prdata = {{16{pan_gain_r[15]}}, pan_gain_r};
      REG_TILT_GAIN:  prdata = {{16{tilt_gain_r[15]}}, tilt_gain_r};
      REG_PAN_LIMIT:  prdata = {17'd0, pan_limit_r};
      REG_TILT_LIMIT: prdata = {17'd0, tilt_limit_r};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  // stage A: input register and status
  logic         a_vld_r;
  ptdc_in_t     a_item_r;
  ptdc_status_t a_stat_r;
  ptdc_status_t a_stat_nxt;

  always_comb begin
    if (in_item.target_confidence < conf_floor_r) begin
      a_stat_nxt = ST_LOW_CONF;
    end else if (width_r == '0 || height_r == '0) begin
      a_stat_nxt = ST_BAD_GEOM;
    end else begin
      a_stat_nxt = ST_DRIVEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= in_item;
    a_stat_r <= a_stat_nxt;
  end

  // error magnitude setup for the normalize divider
  logic [1:0][DW1-1:0] d1_rem;
  logic [1:0][DW1-1:0] d1_den;
  logic [1:0]          e_neg;
  logic [1:0]          e_sat;

  always_comb begin
    logic [15:0]          c;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        an;
    for (int l = 0; l < 2; l++) begin
      c         = (l == 0) ? a_item_r.centroid_x : a_item_r.centroid_y;
      d1_den[l] = DW1'((l == 0) ? width_r : height_r) << CF;
      num       = $signed(NW'({c, 1'b0})) - $signed(NW'(d1_den[l]));
      e_neg[l]  = num[NW-1];
      an        = e_neg[l] ? NW'(-num) : NW'(num);
      e_sat[l]  = an >= NW'(d1_den[l]);
      d1_rem[l] = e_sat[l] ? '0 : an[DW1-1:0];
    end
  end

  logic                   b_vld;
  logic [1:0][Q_BITS-1:0] b_q;
  logic [SW-1:0]          b_side;

  ptdc_div #(.DW(DW1), .SW(SW)) u_div_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (a_vld_r),
    .rem_i  (d1_rem),
    .den_i  (d1_den),
    .side_i ({a_item_r.frame_tag, a_stat_r, e_neg, e_sat}),
    .vld_o  (b_vld),
    .q_o    (b_q),
    .side_o (b_side)
  );

  // deadband rescale setup
  logic [1:0][15:0] d2_rem;
  logic [1:0][15:0] d2_den;
  logic [1:0]       m_sat;

  always_comb begin
    logic [15:0] m;
    logic [15:0] n;
    for (int l = 0; l < 2; l++) begin
      m = b_side[l] ? ONE_Q15 : {1'b0, b_q[l]};
      n = (m < {1'b0, dead_zone_r}) ? 16'd0 : m - {1'b0, dead_zone_r};
      d2_den[l] = ONE_Q15 - {1'b0, dead_zone_r};
      m_sat[l]  = n >= d2_den[l];
      d2_rem[l] = m_sat[l] ? 16'd0 : n;
    end
  end

  logic                   c_vld;
  logic [1:0][Q_BITS-1:0] c_q;
  logic [SW-1:0]          c_side;

  ptdc_div #(.DW(16), .SW(SW)) u_div_dead (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (b_vld),
    .rem_i  (d2_rem),
    .den_i  (d2_den),
    .side_i ({b_side[SW-1:2], m_sat}),
    .vld_o  (c_vld),
    .q_o    (c_q),
    .side_o (c_side)
  );

  // gain multiply
  logic             p_vld_r;
  logic [1:0][31:0] p_r;
  logic [1:0]       p_neg_r;
  logic [31:0]      p_tag_r;
  logic [1:0]       p_stat_r;
  logic [1:0][31:0] p_nxt;
  logic [1:0]       p_neg_nxt;

  always_comb begin
    logic [15:0]        m2;
    logic signed [15:0] gn;
    logic [15:0]        g;
    for (int l = 0; l < 2; l++) begin
      m2 = c_side[l] ? ONE_Q15 : {1'b0, c_q[l]};
      gn = (l == 0) ? pan_gain_r : tilt_gain_r;
      g  = gn[15] ? 16'(-gn) : 16'(gn);
      p_nxt[l]     = 32'(g) * 32'(m2);
      p_neg_nxt[l] = c_side[2 + l] ^ gn[15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    p_neg_r  <= p_neg_nxt;
    p_tag_r  <= c_side[SW-1:6];
    p_stat_r <= c_side[5:4];
  end

  // clamp, sign and output register
  logic      out_valid_r;
  ptdc_out_t out_item_r;
  ptdc_out_t out_item_nxt;

  always_comb begin
    logic [31:0] mag;
    logic [31:0] lim;
    logic [15:0] cl;
    logic [1:0][15:0] sp;
    for (int l = 0; l < 2; l++) begin
      mag = p_r[l] >> PROD_SHIFT;
      lim = 32'((l == 0) ? pan_limit_r : tilt_limit_r);
      cl  = (mag > lim) ? lim[15:0] : mag[15:0];
      sp[l] = p_neg_r[l] ? 16'(-cl) : cl;
      if (p_stat_r != ST_DRIVEN) begin
        sp[l] = '0;
      end
    end
    out_item_nxt.frame_tag_out = p_tag_r;
    out_item_nxt.pan_setpoint  = sp[0];
    out_item_nxt.tilt_setpoint = sp[1];
    out_item_nxt.drive_status  = p_stat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  logic signed [16:0] pan_lim_s;
  logic signed [16:0] tilt_lim_s;
  logic signed [16:0] pan_sp_s;
  logic signed [16:0] tilt_sp_s;
  logic               stat_bad;
  logic               sp_zero;
  logic               pan_in_lim;
  logic               tilt_in_lim;

  assign pan_lim_s   = $signed({2'b00, pan_limit_r});
  assign tilt_lim_s  = $signed({2'b00, tilt_limit_r});
  assign pan_sp_s    = 17'(out_item.pan_setpoint);
  assign tilt_sp_s   = 17'(out_item.tilt_setpoint);
  assign stat_bad    = out_item.drive_status > ST_BAD_GEOM;
  assign sp_zero     = out_item.pan_setpoint == 16'sd0 && out_item.tilt_setpoint == 16'sd0;
  assign pan_in_lim  = pan_sp_s <= pan_lim_s && pan_sp_s >= -pan_lim_s;
  assign tilt_in_lim = tilt_sp_s <= tilt_lim_s && tilt_sp_s >= -tilt_lim_s;

  `ASSERT_ALWAYS(a_latency, clk, rst_n, (start && !busy) |-> ##13 out_valid)
  `ASSERT_NEVER(a_bad_status, clk, rst_n, out_valid && stat_bad)
  `ASSERT_ALWAYS(a_idle_zero, clk, rst_n, (out_valid && out_item.drive_status != ST_DRIVEN) |-> sp_zero)
  `ASSERT_ALWAYS(a_pan_clamp, clk, rst_n, out_valid |-> pan_in_lim)
  `ASSERT_ALWAYS(a_tilt_clamp, clk, rst_n, out_valid |-> tilt_in_lim)

endmodule
